/* rtl/ipdr_pkg.sv */
package ipdr_pkg;

    // Fraction bits of the gains and of the summed terms
    localparam int FRAC_BITS = 16;

    // Field and register widths
    localparam int IN_W       = 16;
    localparam int GAIN_W     = 20;
    localparam int LIM_W      = 24;
    localparam int WIN_W      = 16;
    localparam int DUTY_W     = 16;
    localparam int ERR_W      = IN_W + 1;
    localparam int ESUM_W     = LIM_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int INC_W      = 16;

    // Product and sum widths (gains carry one extra zero sign bit)
    localparam int P_W        = GAIN_W + 1 + ERR_W;
    localparam int I_W        = GAIN_W + 1 + ESUM_W;
    localparam int D_W        = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W      = I_W + 2;

    // Rounding and increment saturation bounds
    localparam logic [SUM_W-1:0] RND_HALF    = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [SUM_W-1:0] RND_POS_MAX = SUM_W'(2 ** (INC_W - 1) - 1);
    localparam logic [SUM_W-1:0] RND_NEG_MAX = SUM_W'(2 ** (INC_W - 1));

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN        = 3'd0,
        CFG_KI_GAIN        = 3'd1,
        CFG_KD_GAIN        = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_ERROR_WINDOW   = 3'd4,
        CFG_DUTY_MAX       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [LIM_W-1:0]  integral_limit;
        logic [WIN_W-1:0]  error_window;
        logic [DUTY_W-1:0] duty_max;
    } t_cfg;

    localparam logic [GAIN_W-1:0] KP_RST  = GAIN_W'(19661);
    localparam logic [GAIN_W-1:0] KI_RST  = GAIN_W'(996);
    localparam logic [GAIN_W-1:0] KD_RST  = GAIN_W'(655);
    localparam logic [LIM_W-1:0]  LIM_RST = LIM_W'(52632);
    localparam logic [WIN_W-1:0]  WIN_RST = WIN_W'(50);
    localparam logic [DUTY_W-1:0] DMAX_RST = DUTY_W'(3200);

endpackage

/* rtl/ipdr_integ.sv */
module ipdr_integ (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ipdr_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ipdr_pkg::IN_W-1:0]    i_target,
    input  logic signed [ipdr_pkg::IN_W-1:0]    i_measured,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ipdr_pkg::ERR_W-1:0]   o_err,
    output logic signed [ipdr_pkg::ESUM_W-1:0]  o_esum,
    output logic signed [ipdr_pkg::DIFF_W-1:0]  o_diff
);
    import ipdr_pkg::*;

    logic                     r_v0;
    logic signed [IN_W-1:0]   r_tgt;
    logic signed [IN_W-1:0]   r_meas;
    logic                     r_v1;
    logic signed [ERR_W-1:0]  r_err;    // also the previous error
    logic signed [ESUM_W-1:0] r_esum;   // also the integral state
    logic signed [DIFF_W-1:0] r_diff;

    logic                     c_ld0;
    logic                     c_ld1;
    logic signed [ERR_W-1:0]  c_err;
    logic [ERR_W-1:0]         c_aerr;
    logic                     c_integ;
    logic signed [ESUM_W:0]   c_acc;
    logic signed [ESUM_W:0]   c_lim;
    logic signed [ESUM_W:0]   c_clamp;
    logic signed [ESUM_W-1:0] n_esum;
    logic signed [DIFF_W-1:0] n_diff;

    // Stage handshake
    assign c_ld1   = r_v0 && (!r_v1 || i_ready);
    assign o_ready = !r_v0 || c_ld1;
    assign c_ld0   = i_valid && o_ready;

    // Error and window test
    assign c_err   = ERR_W'(r_tgt) - ERR_W'(r_meas);
    assign c_aerr  = c_err[ERR_W-1] ? ERR_W'(-c_err) : ERR_W'(c_err);
    assign c_integ = c_aerr < ERR_W'(i_cfg.error_window);

    // Integral update with symmetric clamp, cleared outside the window
    assign c_acc = (ESUM_W + 1)'(r_esum) + (ESUM_W + 1)'(c_err);
    assign c_lim = $signed({2'b00, i_cfg.integral_limit});

    always_comb begin
        if (c_acc > c_lim) begin
            c_clamp = c_lim;
        end else if (c_acc < -c_lim) begin
            c_clamp = -c_lim;
        end else begin
            c_clamp = c_acc;
        end
        n_esum = c_integ ? ESUM_W'(c_clamp) : '0;
    end

    assign n_diff = DIFF_W'(c_err) - DIFF_W'(r_err);

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_err  <= '0;
            r_esum <= '0;
        end else begin
            r_v0 <= c_ld0 ? 1'b1 : (c_ld1 ? 1'b0 : r_v0);
            r_v1 <= c_ld1 ? 1'b1 : (i_ready ? 1'b0 : r_v1);
            if (c_ld1) begin
                r_err  <= c_err;
                r_esum <= n_esum;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (c_ld0) begin
            r_tgt  <= i_target;
            r_meas <= i_measured;
        end
        if (c_ld1) begin
            r_diff <= n_diff;
        end
    end

    assign o_valid = r_v1;
    assign o_err   = r_err;
    assign o_esum  = r_esum;
    assign o_diff  = r_diff;

    // Integral stays within the limit after every update
    a_esum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ld1 |=> (r_esum <= $signed({2'b00, i_cfg.integral_limit}))
               && (r_esum >= -$signed({2'b00, i_cfg.integral_limit})))
        else $error("integral outside limit");

    // Large error clears the integral
    a_esum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ld1 && !c_integ) |=> (r_esum == '0))
        else $error("integral not cleared on large error");

endmodule

/* rtl/ipdr_terms.sv */
module ipdr_terms (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ipdr_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ipdr_pkg::ERR_W-1:0]   i_err,
    input  logic signed [ipdr_pkg::ESUM_W-1:0]  i_esum,
    input  logic signed [ipdr_pkg::DIFF_W-1:0]  i_diff,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ipdr_pkg::P_W-1:0]     o_p,
    output logic signed [ipdr_pkg::I_W-1:0]     o_i,
    output logic signed [ipdr_pkg::D_W-1:0]     o_d
);
    import ipdr_pkg::*;

    logic                r_v;
    logic signed [P_W-1:0] r_p;
    logic signed [I_W-1:0] r_i;
    logic signed [D_W-1:0] r_d;

    logic                c_ld;
    logic signed [P_W-1:0] n_p;
    logic signed [I_W-1:0] n_i;
    logic signed [D_W-1:0] n_d;

    assign o_ready = !r_v || i_ready;
    assign c_ld    = i_valid && o_ready;

    // Three independent gain products
    assign n_p = P_W'($signed({1'b0, i_cfg.kp_gain})) * P_W'(i_err);
    assign n_i = I_W'($signed({1'b0, i_cfg.ki_gain})) * I_W'(i_esum);
    assign n_d = D_W'($signed({1'b0, i_cfg.kd_gain})) * D_W'(i_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= c_ld ? 1'b1 : (i_ready ? 1'b0 : r_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ld) begin
            r_p <= n_p;
            r_i <= n_i;
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_p     = r_p;
    assign o_i     = r_i;
    assign o_d     = r_d;

    // Stalled products are held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && !i_ready) |=> (r_v && $stable(r_p) && $stable(r_i) && $stable(r_d)))
        else $error("products changed while stalled");

endmodule

/* rtl/ipdr_duty.sv */
module ipdr_duty (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ipdr_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ipdr_pkg::P_W-1:0]     i_p,
    input  logic signed [ipdr_pkg::I_W-1:0]     i_i,
    input  logic signed [ipdr_pkg::D_W-1:0]     i_d,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ipdr_pkg::DUTY_W-1:0]         o_duty
);
    import ipdr_pkg::*;

    logic                    r_vi;
    logic signed [INC_W-1:0] r_inc;
    logic                    r_vo;
    logic [DUTY_W-1:0]       r_duty;   // output register and duty state

    logic                    c_ldi;
    logic                    c_ldo;
    logic signed [SUM_W-1:0] c_total;
    logic                    c_neg;
    logic [SUM_W-1:0]        c_mag;
    logic [SUM_W-1:0]        c_rnd;
    logic signed [INC_W-1:0] n_inc;
    logic signed [DUTY_W+1:0] c_sum;
    logic signed [DUTY_W+1:0] c_dmax;
    logic [DUTY_W-1:0]       n_duty;

    // Stage handshake
    assign c_ldo   = r_vi && (!r_vo || i_ready);
    assign o_ready = !r_vi || c_ldo;
    assign c_ldi   = i_valid && o_ready;

    // Sum of terms, round half away from zero, saturate
    assign c_total = SUM_W'(i_p) + SUM_W'(i_i) + SUM_W'(i_d);
    assign c_neg   = c_total[SUM_W-1];
    assign c_mag   = c_neg ? SUM_W'(-c_total) : SUM_W'(c_total);
    assign c_rnd   = (c_mag + RND_HALF) >> FRAC_BITS;

    always_comb begin
        if (!c_neg) begin
            n_inc = (c_rnd > RND_POS_MAX) ? INC_W'(RND_POS_MAX) : INC_W'(c_rnd);
        end else begin
            n_inc = (c_rnd > RND_NEG_MAX) ? INC_W'(RND_NEG_MAX) : -INC_W'(c_rnd);
        end
    end

    // Duty accumulate and clamp to 0..duty_max
    assign c_sum  = $signed({2'b00, r_duty}) + (DUTY_W + 2)'(r_inc);
    assign c_dmax = $signed({2'b00, i_cfg.duty_max});

    always_comb begin
        if (c_sum > c_dmax) begin
            n_duty = i_cfg.duty_max;
        end else if (c_sum[DUTY_W+1]) begin
            n_duty = '0;
        end else begin
            n_duty = DUTY_W'(c_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vi   <= 1'b0;
            r_vo   <= 1'b0;
            r_duty <= '0;
        end else begin
            r_vi <= c_ldi ? 1'b1 : (c_ldo ? 1'b0 : r_vi);
            r_vo <= c_ldo ? 1'b1 : (i_ready ? 1'b0 : r_vo);
            if (c_ldo) begin
                r_duty <= n_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ldi) begin
            r_inc <= n_inc;
        end
    end

    assign o_valid = r_vo;
    assign o_duty  = r_duty;

    // New duty never exceeds the upper clamp
    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ldo |=> (r_duty <= i_cfg.duty_max))
        else $error("duty above duty_max");

    // A waiting result is neither dropped nor altered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !i_ready) |=> (r_vo && $stable(r_duty)))
        else $error("waiting result lost");

endmodule

/* rtl/incremental_pid_duty_regulator_unit.sv */
// Incremental PID duty regulator for one channel. Each request carries a
// setpoint and a measurement; the block forms the error, updates a clamped
// integral (cleared when the error is outside the window), sums the P, I and
// D terms in fixed point, rounds, saturates the increment to 16 bits signed
// and adds it to the held duty, clamped to 0..duty_max. One request is taken
// every cycle unless the result stream stalls. The integral and the duty each
// close their feedback in a single stage, which sets the one-request-per-cycle
// rate. The user must write gains and limits through the configuration port
// only while no request is in flight; the block itself does not enforce this.
module incremental_pid_duty_regulator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [ipdr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ipdr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,  // target_value, measured_sample
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata   // duty_value
);
    import ipdr_pkg::*;

    t_cfg r_cfg;

    logic                     c_v1;
    logic                     c_r1;
    logic signed [ERR_W-1:0]  c_err;
    logic signed [ESUM_W-1:0] c_esum;
    logic signed [DIFF_W-1:0] c_diff;
    logic                     c_v2;
    logic                     c_r2;
    logic signed [P_W-1:0]    c_p;
    logic signed [I_W-1:0]    c_i;
    logic signed [D_W-1:0]    c_d;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain        <= KP_RST;
            r_cfg.ki_gain        <= KI_RST;
            r_cfg.kd_gain        <= KD_RST;
            r_cfg.integral_limit <= LIM_RST;
            r_cfg.error_window   <= WIN_RST;
            r_cfg.duty_max       <= DMAX_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP_GAIN:        r_cfg.kp_gain        <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_GAIN:        r_cfg.ki_gain        <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_GAIN:        r_cfg.kd_gain        <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[LIM_W-1:0];
                CFG_ERROR_WINDOW:   r_cfg.error_window   <= i_cfg_data[WIN_W-1:0];
                CFG_DUTY_MAX:       r_cfg.duty_max       <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Error and integral
    ipdr_integ u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_target   ($signed(s_axis_tdata[15:0])),
        .i_measured ($signed(s_axis_tdata[31:16])),
        .o_valid    (c_v1),
        .i_ready    (c_r1),
        .o_err      (c_err),
        .o_esum     (c_esum),
        .o_diff     (c_diff)
    );

    // Gain products
    ipdr_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (c_v1),
        .o_ready (c_r1),
        .i_err   (c_err),
        .i_esum  (c_esum),
        .i_diff  (c_diff),
        .o_valid (c_v2),
        .i_ready (c_r2),
        .o_p     (c_p),
        .o_i     (c_i),
        .o_d     (c_d)
    );

    // Rounding, increment and duty output
    ipdr_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (c_v2),
        .o_ready (c_r2),
        .i_p     (c_p),
        .i_i     (c_i),
        .i_d     (c_d),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_duty  (m_axis_tdata)
    );

endmodule

/* bench/tb_incremental_pid_duty_regulator_unit.sv */
`timescale 1ns / 1ps

module tb_incremental_pid_duty_regulator_unit;
    import ipdr_pkg::*;

    // Extra settling wait after the result queue has drained
    localparam int PIPE_LAT = 4;

    // Register indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    typedef enum int {SET_RESET, SET_TOP, SET_FLOOR, SET_MIXED} t_setting;

    // Directed row: a sample (a = target, b = measurement) or a register write
    // (a = index, b = data); typed rows carry a duty worked out by hand
    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] a;
        logic [23:0] b;
        logic        typed;
        logic [15:0] duty;
    } t_plan_row;

    localparam int PLAN_LEN = 28;

    t_plan_row plan [0:PLAN_LEN-1] = '{
        // after reset, then both input extremes
        '{ROW_SAMPLE, 24'd0,      24'd0,      1'b1, 16'd0},
        '{ROW_SAMPLE, 24'h7FFF,   24'h8000,   1'b1, 16'd3200},
        '{ROW_SAMPLE, 24'h8000,   24'h7FFF,   1'b1, 16'd0},
        // errors around the window edge (integrate, then clear at 50)
        '{ROW_SAMPLE, 24'd100,    24'd90,     1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd100,    24'd60,     1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd100,    24'd51,     1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd100,    24'd50,     1'b0, 16'd0},
        '{ROW_SAMPLE, 24'hFF9C,   24'hFFCD,   1'b0, 16'd0},
        // top gains with stray upper data bits, limit lowered below the sum
        '{ROW_WRITE,  24'(CFG_KP_GAIN),        24'hFFFFFF, 1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_KI_GAIN),        24'hFFFFFF, 1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_KD_GAIN),        24'hFFFFFF, 1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_INTEGRAL_LIMIT), 24'd5,      1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_ERROR_WINDOW),   24'hFFFFFF, 1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_DUTY_MAX),       24'hFFFFFF, 1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_IDX_SPARE_A),    24'h000001, 1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_IDX_SPARE_B),    24'h000002, 1'b0, 16'd0},
        '{ROW_SAMPLE, 24'hFFFF,   24'd0,      1'b0, 16'd0},
        '{ROW_SAMPLE, 24'h7FFF,   24'h8000,   1'b0, 16'd0},
        '{ROW_SAMPLE, 24'h8000,   24'h7FFF,   1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd0,      24'd0,      1'b0, 16'd0},
        // zero window never integrates, zero duty cap pins the duty
        '{ROW_WRITE,  24'(CFG_ERROR_WINDOW),   24'd0,      1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_DUTY_MAX),       24'd0,      1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd1000,   24'd0,      1'b1, 16'd0},
        '{ROW_SAMPLE, 24'hFFFB,   24'd3,      1'b1, 16'd0},
        // smallest legal cap
        '{ROW_WRITE,  24'(CFG_DUTY_MAX),       24'd1,      1'b0, 16'd0},
        '{ROW_WRITE,  24'(CFG_ERROR_WINDOW),   24'd50,     1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd5,      24'd0,      1'b0, 16'd0},
        '{ROW_SAMPLE, 24'd0,      24'd5,      1'b0, 16'd0}
    };

    localparam int N_PHASES = 7;
    t_setting phase_setting [0:N_PHASES-1] = '{SET_RESET, SET_TOP, SET_FLOOR,
                                               SET_MIXED, SET_MIXED, SET_MIXED,
                                               SET_MIXED};
    int phase_len [0:N_PHASES-1] = '{130, 130, 40, 140, 140, 140, 140};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // target_value, measured_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // duty_value

    // Predictor registers and state
    logic [GAIN_W-1:0] gain_p     = KP_RST;
    logic [GAIN_W-1:0] gain_i     = KI_RST;
    logic [GAIN_W-1:0] gain_d     = KD_RST;
    logic [LIM_W-1:0]  sum_limit  = LIM_RST;
    logic [WIN_W-1:0]  int_window = WIN_RST;
    logic [DUTY_W-1:0] duty_cap   = DMAX_RST;
    longint            int_acc    = 0;
    longint            prev_err   = 0;
    longint            duty_hold  = 0;

    logic [15:0] duty_q [$];
    int          fail_cnt      = 0;
    int          results_seen  = 0;
    int          burst_left    = 0;
    bit          sender_quiet  = 1'b0;

    incremental_pid_duty_regulator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_incremental_pid_duty_regulator_unit NOT OK");
        $finish;
    end

    // One regulator step: windowed integral, PID sum, round, saturate, clamp
    function automatic logic [15:0] predict_duty(input logic signed [15:0] tgt,
                                                 input logic signed [15:0] meas);
        longint err, aerr, total, mag, inc, nxt;
        err  = longint'(tgt) - longint'(meas);
        aerr = (err < 0) ? -err : err;
        if (aerr < longint'(int_window)) begin
            int_acc = int_acc + err;
            if (int_acc > longint'(sum_limit))
                int_acc = longint'(sum_limit);
            if (int_acc < -longint'(sum_limit))
                int_acc = -longint'(sum_limit);
        end else begin
            int_acc = 0;
        end
        total = longint'(gain_p) * err + longint'(gain_i) * int_acc
              + longint'(gain_d) * (err - prev_err);
        prev_err = err;
        // round half away from zero
        mag = (total < 0) ? -total : total;
        mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        inc = (total < 0) ? -mag : mag;
        if (inc > 32767)
            inc = 32767;
        if (inc < -32768)
            inc = -32768;
        nxt = duty_hold + inc;
        if (nxt > longint'(duty_cap))
            nxt = longint'(duty_cap);
        if (nxt < 0)
            nxt = 0;
        duty_hold = nxt;
        return 16'(nxt);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_cnt++;
        $display("%0t: duty %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // Register write; the enable is dropped before the task returns so back-to-back writes never collide
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KP_GAIN:        gain_p     = data[GAIN_W-1:0];
            CFG_KI_GAIN:        gain_i     = data[GAIN_W-1:0];
            CFG_KD_GAIN:        gain_d     = data[GAIN_W-1:0];
            CFG_INTEGRAL_LIMIT: sum_limit  = data[LIM_W-1:0];
            CFG_ERROR_WINDOW:   int_window = data[WIN_W-1:0];
            CFG_DUTY_MAX:       duty_cap   = data[DUTY_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one request, wait for it to be taken, log its expected duty,
    // then maybe close the burst with a gap
    task automatic push_sample(input logic [15:0] tgt, input logic [15:0] meas,
                               input logic typed, input logic [15:0] typed_duty);
        logic [15:0] calc;
        int          gap;
        s_axis_tdata  <= {meas, tgt};
        s_axis_tvalid <= 1'b1;
        do @(negedge i_clk); while (s_axis_tready !== 1'b1);
        @(posedge i_clk);
        calc = predict_duty(tgt, meas);
        duty_q.push_back(typed ? typed_duty : calc);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (!sender_quiet && gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and let every outstanding request come back
    task automatic settle_pipe();
        s_axis_tvalid <= 1'b0;
        while (duty_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // Program all registers for one phase; stray bits above each width
    task automatic load_setting(input t_setting which);
        logic [CFG_DATA_W-1:0] val [0:5];
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        case (which)
            SET_RESET: val = '{24'(KP_RST), 24'(KI_RST), 24'(KD_RST), 24'(LIM_RST),
                               24'(WIN_RST), 24'(DMAX_RST)};
            SET_TOP:   val = '{24'hFFFFF, 24'hFFFFF, 24'hFFFFF, 24'hFFFFFF,
                               24'hFFFF, 24'hFFFF};
            SET_FLOOR: val = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1};
            default: begin
                val[0] = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                         : $urandom_range(0, 1 << 17));
                val[1] = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                         : $urandom_range(0, 1 << 12));
                val[2] = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                         : $urandom_range(0, 1 << 16));
                val[3] = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                         : $urandom_range(0, 4000));
                val[4] = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                         : $urandom_range(0, 300));
                val[5] = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                         : $urandom_range(100, 4000));
            end
        endcase
        for (int r = 0; r < 6; r++) begin
            mask = (r == CFG_INTEGRAL_LIMIT) ? 24'hFFFFFF :
                   (r >= CFG_ERROR_WINDOW)   ? 24'h00FFFF : 24'h0FFFFF;
            junk = 24'($urandom);
            cfg_write(CFG_IDX_W'(r), (junk & ~mask) | (val[r] & mask));
        end
        if ($urandom_range(0, 1) == 0)
            cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                      24'($urandom));
    endtask

    // Result checker; samples mid-cycle so the accepting edge is unambiguous
    always @(negedge i_clk) begin : duty_check
        logic [15:0] want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            results_seen++;
            if (duty_q.size() == 0) begin
                report_mismatch("with nothing pending", m_axis_tdata, 16'd0);
            end else begin
                want = duty_q.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("mismatch", m_axis_tdata, want);
            end
        end
    end

    // Result sink: stall patterns in stretches, plus one long hold-off
    initial begin : duty_sink
        int  mode;
        int  left;
        int  hold;
        bit  hold_done;
        mode = 0;
        left = 0;
        hold = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_seen >= 330) begin
                hold_done = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (left % 5 != 0);
                endcase
            end
        end
    end

    // Stimulus: reset, directed table, then randomized phases
    initial begin : stim
        bit                 in_flight;
        int                 span;
        int                 delta;
        int                 mi;
        logic signed [15:0] tgt;
        logic        [15:0] meas;
        in_flight = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_KP_GAIN;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (in_flight) begin
                    settle_pipe();
                    in_flight = 1'b0;
                end
                cfg_write(plan[i].a[CFG_IDX_W-1:0], plan[i].b);
            end else begin
                push_sample(plan[i].a[15:0], plan[i].b[15:0], plan[i].typed, plan[i].duty);
                in_flight = 1'b1;
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle_pipe();
            load_setting(phase_setting[p]);
            sender_quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len[p]; n++) begin
                tgt = 16'($urandom);
                if ($urandom_range(0, 9) < 8) begin
                    // measurement near the setpoint so the integral gets exercised
                    span  = (int_window > 16'd1000) ? 1000 : int'(int_window) + 6;
                    delta = int'($urandom_range(0, 2 * span)) - span;
                    mi    = int'(tgt) - delta;
                    if (mi > 32767 || mi < -32768)
                        mi = int'(tgt) + delta;
                    meas = 16'(mi);
                end else begin
                    meas = 16'($urandom);
                end
                push_sample(tgt, meas, 1'b0, 16'd0);
            end
        end
        settle_pipe();

        if (fail_cnt == 0)
            $display("tb_incremental_pid_duty_regulator_unit OK");
        else
            $display("tb_incremental_pid_duty_regulator_unit NOT OK");
        $finish;
    end

endmodule
